[sv/rob_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rob_pkg: shared types and constants of the in-order release reorder buffer
// Window size, field widths, result kinds and the word types that travel
// between the input queue, the engine and the top level.
// ----------------------------------------------------------------------------
package rob_pkg;

  // Reorder window and stored tag width
  localparam int WINDOW   = 64;
  localparam int TAG_BITS = 32;

  // Port field widths
  localparam int SEQ_W     = 64;
  localparam int IN_TAG_W  = 32;
  localparam int OUT_TAG_W = 32;
  localparam int KIND_W    = 2;
  localparam int LIMIT_W   = 7;

  // Derived widths
  localparam int IDX_W = $clog2(WINDOW);
  localparam int CNT_W = $clog2(WINDOW + 1);
  localparam int CMP_W = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;

  // Overrun limit after reset
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(64);

  // Input queue depth
  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  // Result kinds
  typedef enum logic [KIND_W-1:0] {
    KIND_REL  = 2'd0,
    KIND_DROP = 2'd1,
    KIND_OVR  = 2'd2
  } kind_t;

  // One input word as held in the queue
  typedef struct packed {
    logic [SEQ_W-1:0]    seq;
    logic [TAG_BITS-1:0] tag;
  } item_t;

  // One result word
  typedef struct packed {
    kind_t                kind;
    logic [SEQ_W-1:0]     seq;
    logic [OUT_TAG_W-1:0] tag;
    logic                 last;
  } result_t;

endpackage

[sv/rob_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rob_queue: front-end input queue
// Accepts input words and holds them in a short FIFO until the engine takes
// them, so the sender keeps moving while the engine is draining.
// ----------------------------------------------------------------------------
module rob_queue import rob_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  output logic  in_ready,
  input  item_t in_item,
  output logic  q_valid,
  input  logic  q_pop,
  output item_t q_item
);

  item_t              ent_r [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [Q_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [Q_CNT_W-1:0] cnt_r, cnt_nxt;
  logic               push;
  logic               pop;

  assign in_ready = (cnt_r != Q_CNT_W'(Q_DEPTH));
  assign q_valid  = (cnt_r != '0);
  assign q_item   = ent_r[rd_ptr_r];
  assign push     = in_valid && in_ready;
  assign pop      = q_pop && q_valid;

  // Pointer and fill count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_r + Q_PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_r + Q_PTR_W'(1);
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + Q_CNT_W'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - Q_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Entry storage, no reset
  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wr_ptr_r] <= in_item;
    end
  end

endmodule

[sv/rob_engine.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rob_engine: back-end reorder engine
// Classifies a queued word against the expected sequence number, drops it or
// stores its tag in the slot memory, releases the run of consecutive slots
// one by one, clears the store on overrun. Results leave via an output register.
// ----------------------------------------------------------------------------
module rob_engine import rob_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [LIMIT_W-1:0] limit,
  input  logic               q_valid,
  output logic               q_pop,
  input  item_t              q_item,
  output logic               res_valid,
  input  logic               res_ready,
  output result_t            res
);

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_CLASS = 6'b000010,
    ST_DRAIN = 6'b000100,
    ST_REL   = 6'b001000,
    ST_DROP  = 6'b010000,
    ST_CHECK = 6'b100000
  } state_t;

  state_t              state_r, state_nxt;
  logic [SEQ_W-1:0]    seq_r, seq_nxt;
  logic [TAG_BITS-1:0] tag_r, tag_nxt;
  logic [SEQ_W-1:0]    exp_r, exp_nxt;
  logic [IDX_W-1:0]    head_r, head_nxt;
  logic [CNT_W-1:0]    held_r, held_nxt;
  logic [WINDOW-1:0]   valid_r, valid_nxt;
  logic                out_valid_r, out_valid_nxt;
  result_t             out_r, out_nxt;

  // Slot tag memory
  logic [TAG_BITS-1:0] mem [WINDOW];
  logic [TAG_BITS-1:0] rd_r;
  logic                mem_we;

  logic [SEQ_W-1:0]    offset;
  logic                drop;
  logic [IDX_W:0]      slot_sum;
  logic [IDX_W-1:0]    slot;
  logic [IDX_W-1:0]    head_inc;
  logic [CNT_W-1:0]    held_dec;
  logic                ovr;
  logic                ovr_dec;
  logic                out_free;

  // Distance of a sequence number from the expected one, modulo 2^64
  function automatic logic [SEQ_W-1:0] q_item_seq_dist(input logic [SEQ_W-1:0] s,
                                                       input logic [SEQ_W-1:0] e);
    return s - e;
  endfunction

  // Window classification and slot address
  assign offset   = q_item_seq_dist(seq_r, exp_r);
  assign drop     = (offset >= SEQ_W'(WINDOW));
  assign slot_sum = {1'b0, head_r} + {1'b0, offset[IDX_W-1:0]};
  assign slot     = (slot_sum >= (IDX_W+1)'(WINDOW)) ?
                    IDX_W'(slot_sum - (IDX_W+1)'(WINDOW)) : slot_sum[IDX_W-1:0];
  assign head_inc = (head_r == IDX_W'(WINDOW - 1)) ? '0 : head_r + IDX_W'(1);

  // Overrun tests now and after the release in progress
  assign held_dec = held_r - CNT_W'(1);
  assign ovr      = CMP_W'(held_r) > CMP_W'(limit);
  assign ovr_dec  = CMP_W'(held_dec) > CMP_W'(limit);

  assign out_free  = !out_valid_r || res_ready;
  assign res_valid = out_valid_r;
  assign res       = out_r;

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    seq_nxt       = seq_r;
    tag_nxt       = tag_r;
    exp_nxt       = exp_r;
    head_nxt      = head_r;
    held_nxt      = held_r;
    valid_nxt     = valid_r;
    out_valid_nxt = out_valid_r;
    out_nxt       = out_r;
    q_pop         = 1'b0;
    mem_we        = 1'b0;

    if (out_valid_r && res_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (q_valid) begin
          q_pop     = 1'b1;
          seq_nxt   = q_item.seq;
          tag_nxt   = q_item.tag;
          state_nxt = ST_CLASS;
        end
      end
      ST_CLASS: begin
        if (drop) begin
          state_nxt = ST_DROP;
        end else begin
          mem_we = 1'b1;
          if (!valid_r[slot]) begin
            held_nxt = held_r + CNT_W'(1);
          end
          valid_nxt[slot] = 1'b1;
          state_nxt       = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_nxt = valid_r[head_r] ? ST_REL : ST_CHECK;
      end
      ST_REL: begin
        if (out_free) begin
          out_valid_nxt     = 1'b1;
          out_nxt.kind      = KIND_REL;
          out_nxt.seq       = exp_r;
          out_nxt.tag       = OUT_TAG_W'(rd_r);
          out_nxt.last      = !valid_r[head_inc] && !ovr_dec;
          valid_nxt[head_r] = 1'b0;
          held_nxt          = held_dec;
          exp_nxt           = exp_r + SEQ_W'(1);
          head_nxt          = head_inc;
          state_nxt         = ST_DRAIN;
        end
      end
      ST_DROP: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_nxt.kind  = KIND_DROP;
          out_nxt.seq   = seq_r;
          out_nxt.tag   = '0;
          out_nxt.last  = !ovr;
          state_nxt     = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (!ovr) begin
          state_nxt = ST_IDLE;
        end else if (out_free) begin
          out_valid_nxt = 1'b1;
          out_nxt.kind  = KIND_OVR;
          out_nxt.seq   = seq_r;
          out_nxt.tag   = '0;
          out_nxt.last  = 1'b1;
          valid_nxt     = '0;
          held_nxt      = '0;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      exp_r       <= '0;
      head_r      <= '0;
      held_r      <= '0;
      valid_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      exp_r       <= exp_nxt;
      head_r      <= head_nxt;
      held_r      <= held_nxt;
      valid_r     <= valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    seq_r <= seq_nxt;
    tag_r <= tag_nxt;
    out_r <= out_nxt;
  end

  // Tag memory: one write port, registered read at the head slot
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[slot] <= tag_r;
    end
    rd_r <= mem[head_r];
  end

endmodule

[sv/in_order_release_reorder_buffer.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// in_order_release_reorder_buffer: sequence reorder buffer, in-order release
// Takes tagged frames in any order and releases them by sequence number.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready, in_seq, in_tag): one frame per word.
//   Output channel (out_valid/out_ready): zero or more result words per
//   input word; out_last marks the final one. out_kind tells a released
//   frame, a frame dropped outside the window, or an overrun clear.
//   cfg_we/cfg_wdata writes the overrun limit; write it only while idle.
// Timing:
//   A word enters a two-deep input queue, then the engine steps through pop,
//   classify, head test and overrun check for an item that releases nothing,
//   plus a release step and a head test per released frame, since each
//   release tests a valid bit and then reads the tag memory at the head slot.
//   With the engine idle, a drop word comes out sooner than any other result.
// Reset:
//   Synchronous, active low. Valid bits, counters and the expected sequence
//   number clear at once; no memory sweep. The limit returns to 64.
// Stall:
//   A stalled receiver holds the output register; the engine waits, and the
//   input queue keeps taking words until it fills.
// ----------------------------------------------------------------------------
module in_order_release_reorder_buffer import rob_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [LIMIT_W-1:0]   cfg_wdata,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [SEQ_W-1:0]     in_seq,
  input  logic [IN_TAG_W-1:0]  in_tag,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [KIND_W-1:0]    out_kind,
  output logic [SEQ_W-1:0]     out_seq,
  output logic [OUT_TAG_W-1:0] out_tag,
  output logic                 out_last
);

  logic [LIMIT_W-1:0] limit_r, limit_nxt;
  item_t              in_item;
  item_t              q_item;
  logic               q_valid;
  logic               q_pop;
  result_t            res;

  // Overrun limit register
  assign limit_nxt = cfg_we ? cfg_wdata : limit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= LIMIT_RESET;
    end else begin
      limit_r <= limit_nxt;
    end
  end

  assign in_item.seq = in_seq;
  assign in_item.tag = TAG_BITS'(in_tag);

  // Front end: input queue
  rob_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .q_valid  (q_valid),
    .q_pop    (q_pop),
    .q_item   (q_item)
  );

  // Back end: reorder engine
  rob_engine u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .limit     (limit_r),
    .q_valid   (q_valid),
    .q_pop     (q_pop),
    .q_item    (q_item),
    .res_valid (out_valid),
    .res_ready (out_ready),
    .res       (res)
  );

  assign out_kind = res.kind;
  assign out_seq  = res.seq;
  assign out_tag  = res.tag;
  assign out_last = res.last;

`ifndef SYNTHESIS
  // An overrun clear always ends the results of its input
  a_ovr_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind == KIND_OVR) |-> out_last)
    else $error("overrun result not marked last");

  // Status results carry no tag
  a_status_tag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind != KIND_REL) |-> (out_tag == '0))
    else $error("status result with nonzero tag");

  // A released frame that is not last is followed by a release or an overrun
  a_rel_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && (out_kind == KIND_REL) && !out_last
    |=> !out_valid || (out_kind == KIND_REL) || (out_kind == KIND_OVR))
    else $error("release run broken by a drop result");
`endif

endmodule

[dv/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the in-order release reorder buffer
// Drives tagged frames with bursty valid and a patterned output stall, and
// predicts every release, drop and overrun clear from a cycle-free shadow
// of the window. Each result word is checked field by field in order.
// Overrun limit settings change between phases while the block is idle.
// ----------------------------------------------------------------------------
module tb_top;
  import rob_pkg::*;

  localparam int FRAME_GOAL = 410;     // frames to send in total
  localparam int PHASE_LEN  = 55;      // random frames per limit setting
  localparam int DRAIN_CYC  = 40;      // quiet cycles before a limit write
  localparam int CYCLE_CAP  = 400000;  // watchdog

  // Clock, reset and DUT ports
  logic                 clk;
  logic                 rst_n     = 1'b0;
  logic                 cfg_we    = 1'b0;
  logic [LIMIT_W-1:0]   cfg_wdata = '0;
  logic                 in_valid  = 1'b0;
  logic                 in_ready;
  logic [SEQ_W-1:0]     in_seq    = '0;
  logic [IN_TAG_W-1:0]  in_tag    = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b1;
  logic [KIND_W-1:0]    out_kind;
  logic [SEQ_W-1:0]     out_seq;
  logic [OUT_TAG_W-1:0] out_tag;
  logic                 out_last;

  in_order_release_reorder_buffer dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_seq    (in_seq),
    .in_tag    (in_tag),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_kind  (out_kind),
    .out_seq   (out_seq),
    .out_tag   (out_tag),
    .out_last  (out_last)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Shadow of the reorder window
  bit                  frame_held [WINDOW];
  logic [TAG_BITS-1:0] frame_tag  [WINDOW];
  logic [SEQ_W-1:0]    next_seq   = '0;
  logic [IDX_W-1:0]    head_idx   = '0;
  int                  held_cnt   = 0;
  logic [LIMIT_W-1:0]  ovr_limit  = LIMIT_RESET;

  item_t   frame_q [$];   // frames waiting for the driver
  result_t due_q   [$];   // result words still owed by the block

  int frames_planned = 0;
  int limit_writes   = 0;
  int n_rel = 0, n_drop = 0, n_ovr = 0;
  int n_fail = 0;
  int cycles = 0;

  // Apply one accepted frame to the shadow and queue the words it owes
  task automatic predict_frame(input logic [SEQ_W-1:0] seq, input logic [IN_TAG_W-1:0] tag);
    logic [SEQ_W-1:0] ofs;
    logic [IDX_W-1:0] slot;
    result_t          owed [WINDOW+2];
    int               n;
    n = 0;
    ofs = seq - next_seq;
    if (ofs >= SEQ_W'(WINDOW)) begin
      owed[n] = '{kind: KIND_DROP, seq: seq, tag: '0, last: 1'b0};
      n++;
    end else begin
      slot = IDX_W'((int'(head_idx) + int'(ofs[IDX_W:0])) % WINDOW);
      if (!frame_held[slot]) begin
        frame_held[slot] = 1'b1;
        held_cnt++;
      end
      frame_tag[slot] = tag[TAG_BITS-1:0];
      // release the consecutive run at the head
      while (frame_held[head_idx] && n < WINDOW) begin
        owed[n] = '{kind: KIND_REL, seq: next_seq,
                    tag: OUT_TAG_W'(frame_tag[head_idx]), last: 1'b0};
        n++;
        frame_held[head_idx] = 1'b0;
        held_cnt--;
        next_seq++;
        head_idx = IDX_W'((int'(head_idx) + 1) % WINDOW);
      end
    end
    // overrun check runs after every frame, drops included
    if (held_cnt > int'(ovr_limit)) begin
      foreach (frame_held[i]) frame_held[i] = 1'b0;
      held_cnt = 0;
      owed[n] = '{kind: KIND_OVR, seq: seq, tag: '0, last: 1'b0};
      n++;
    end
    if (n > 0) owed[n-1].last = 1'b1;
    for (int i = 0; i < n; i++) due_q.push_back(owed[i]);
  endtask

  // Monitor: check result words, then track accepted frames and limit writes
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_we) ovr_limit = cfg_wdata;
      if (out_valid && out_ready) begin
        case (kind_t'(out_kind))
          KIND_REL:  n_rel++;
          KIND_DROP: n_drop++;
          KIND_OVR:  n_ovr++;
          default: ;
        endcase
        if (due_q.size() == 0) begin
          n_fail++;
          if (n_fail <= 10)
            $display("ERROR @%0t: unexpected word kind=%0d seq=%h tag=%h last=%b",
                     $realtime, out_kind, out_seq, out_tag, out_last);
        end else begin
          result_t want;
          want = due_q.pop_front();
          if (out_kind !== want.kind || out_seq !== want.seq ||
              out_tag !== want.tag || out_last !== want.last) begin
            n_fail++;
            if (n_fail <= 10) begin
              $display("ERROR @%0t: word mismatch", $realtime);
              $display("  expected kind=%0d seq=%h tag=%h last=%b",
                       want.kind, want.seq, want.tag, want.last);
              $display("  actual   kind=%0d seq=%h tag=%h last=%b",
                       out_kind, out_seq, out_tag, out_last);
            end
          end
        end
      end
      if (in_valid && in_ready) predict_frame(in_seq, in_tag);
    end
  end

  // Driver: bursts of frames with random gaps, some long unbroken stretches
  int    burst_left = 1;
  int    gap_left   = 0;
  item_t drv_word;
  always @(posedge clk) begin
    if (rst_n && (!in_valid || in_ready)) begin
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (frame_q.size() != 0) begin
        drv_word = frame_q.pop_front();
        in_valid <= 1'b1;
        in_seq   <= drv_word.seq;
        in_tag   <= drv_word.tag;
        if (burst_left > 1) begin
          burst_left--;
        end else if ($urandom_range(0, 9) < 2) begin
          burst_left = $urandom_range(30, 60);
          gap_left   = 0;
        end else begin
          burst_left = $urandom_range(1, 8);
          gap_left   = $urandom_range(0, 6);
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: stall style is picked by bits 10 to 8 of the cycle counter
  int hold_left = 0;
  always @(posedge clk) begin
    case (cycles[10:8])
      3'd0, 3'd1: out_ready <= 1'b1;
      3'd2:       out_ready <= 1'($urandom_range(0, 1));
      3'd3:       out_ready <= (cycles[2:0] < 3'd5);
      default: begin
        if (hold_left > 0) begin
          hold_left--;
          out_ready <= 1'b0;
        end else if ($urandom_range(0, 15) == 0) begin
          hold_left = $urandom_range(1, 24);
          out_ready <= 1'b0;
        end else begin
          out_ready <= 1'b1;
        end
      end
    endcase
  end

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_CAP) begin
      $display("Timeout after %0d cycles, %0d words still owed", cycles, due_q.size());
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic queue_frame(input logic [SEQ_W-1:0] seq, input logic [IN_TAG_W-1:0] tag);
    item_t w;
    w.seq = seq;
    w.tag = tag;
    frame_q.push_back(w);
    frames_planned++;
  endtask

  // Every planned frame handed over and taken by the block
  task automatic wait_accepted();
    do @(negedge clk); while (frame_q.size() != 0 || in_valid);
  endtask

  // Limit writes only with the block idle: all words back, pipe drained
  task automatic set_limit(input int value);
    wait_accepted();
    while (due_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYC) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= LIMIT_W'(value);
    @(posedge clk);
    cfg_we    <= 1'b0;
    limit_writes++;
    @(negedge clk);
  endtask

  // One random burst planned against the current expected number
  task automatic plan_burst();
    logic [SEQ_W-1:0] base;
    int               pick, n, j, t;
    int               order [WINDOW];
    wait_accepted();
    base = next_seq;
    t = $urandom_range(0, 99);
    n = (t < 80) ? $urandom_range(1, 6) : (t < 95) ? $urandom_range(7, 20) : WINDOW;
    pick = $urandom_range(0, 99);
    if (pick < 55) begin
      // well-formed: every number of a run, shuffled
      for (int k = 0; k < n; k++) order[k] = k;
      for (int k = n - 1; k > 0; k--) begin
        j = $urandom_range(0, k);
        t = order[k];
        order[k] = order[j];
        order[j] = t;
      end
      for (int k = 0; k < n; k++) queue_frame(base + order[k], $urandom);
    end else if (pick < 75) begin
      // broken run: holes and repeats
      for (int k = 0; k < n; k++) queue_frame(base + $urandom_range(0, n), $urandom);
    end else if (pick < 90) begin
      // out-of-window noise and the far edge of the window
      for (int k = $urandom_range(1, 3); k > 0; k--) begin
        case ($urandom_range(0, 3))
          0: queue_frame(base - 1 - $urandom_range(0, 200), $urandom);
          1: queue_frame(base + WINDOW + $urandom_range(0, 500), $urandom);
          2: queue_frame({$urandom, $urandom}, $urandom);
          default: queue_frame(base + WINDOW - 1, $urandom);
        endcase
      end
    end else begin
      // tag replaced before release
      queue_frame(base + 1, $urandom);
      queue_frame(base + 1, $urandom);
      queue_frame(base, $urandom);
    end
  endtask

  // Stimulus
  initial begin
    int phase;
    int phase_start;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // directed: window edges, duplicates, drops at the field extremes
    set_limit(64);
    queue_frame(64'd0, 32'hFFFF_FFFF);
    queue_frame(64'd2, 32'h0000_0000);
    queue_frame(64'd2, 32'hA5A5_A5A5);
    queue_frame(64'd1, 32'h5A5A_5A5A);
    queue_frame(64'd0, 32'h0000_0001);
    queue_frame(64'd3 + WINDOW, 32'h0000_0002);
    queue_frame(64'd2 + WINDOW, 32'h0000_0003);
    queue_frame({SEQ_W{1'b1}}, 32'hFFFF_FFFF);
    queue_frame(64'd5, 32'h0000_0004);
    queue_frame(64'd4, 32'h0000_0005);
    queue_frame(64'd3, 32'h0000_0006);
    queue_frame(64'h8000_0000_0000_0000, 32'h0000_0000);
    queue_frame(64'h5555_5555_5555_5555, 32'h5555_5555);
    queue_frame(64'hAAAA_AAAA_AAAA_AAAA, 32'hAAAA_AAAA);
    queue_frame(64'd9, 32'h0000_0009);

    // directed: tightest limit, overrun after a drop and after stores
    set_limit(1);
    queue_frame(64'd0, 32'h0000_0000);
    queue_frame(64'd7, 32'h0000_0007);
    queue_frame(64'd8, 32'h0000_0008);
    queue_frame(64'd6, 32'h0000_0009);
    queue_frame(64'd8, 32'h0000_000A);
    queue_frame(64'd7, 32'h0000_000B);
    queue_frame(64'd10, 32'h0000_000C);
    queue_frame(64'd11, 32'h0000_000D);

    // random phases, each under its own limit
    phase = 0;
    while (frames_planned < FRAME_GOAL) begin
      case (phase % 6)
        0: set_limit(64);
        1: set_limit(1);
        2: set_limit(2);
        3: set_limit($urandom_range(3, 62));
        4: set_limit(63);
        default: set_limit($urandom_range(1, 8));
      endcase
      phase_start = frames_planned;
      while (frames_planned - phase_start < PHASE_LEN && frames_planned < FRAME_GOAL)
        plan_burst();
      phase++;
    end

    wait_accepted();
    while (due_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYC) @(posedge clk);

    $display("Sent %0d frames under %0d limit settings in %0d cycles",
             frames_planned, limit_writes, cycles);
    $display("Words seen: %0d released, %0d dropped, %0d overrun clears, %0d errors",
             n_rel, n_drop, n_ovr, n_fail);
    if (n_fail == 0 && due_q.size() == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule
